/* design/weekly_schedule_table_assert.svh */
// Assertion macros shared by the weekly schedule table RTL.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef WEEKLY_SCHEDULE_TABLE_ASSERT_SVH
`define WEEKLY_SCHEDULE_TABLE_ASSERT_SVH

// Condition holds at every clock edge out of reset
`define WST_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication
`define WST_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define WST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/wst_pkg.sv */
// Package for the weekly schedule table: sizes, time constants, op codes,
// entry layout and the control struct of the query unit. No dependencies.
package wst_pkg;

    localparam int MAX_EVENTS = 16;
    localparam int IDX_W      = $clog2(MAX_EVENTS);
    localparam int CNT_W      = 5;
    localparam int TOD_W      = 17;
    localparam int AGO_W      = 20;
    localparam int DAYS       = 7;
    localparam int IN_W       = 72;
    localparam int OUT_W      = 16;

    localparam logic [TOD_W-1:0] DAY_SECS  = 17'd86400;
    localparam logic [AGO_W-1:0] WEEK_SECS = 20'd604800;

    // operation codes carried on tuser
    localparam logic [1:0] KIND_QUERY  = 2'd0;
    localparam logic [1:0] KIND_UPSERT = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    // one table entry, 64 bits: id lowest, state highest
    typedef struct packed {
        logic [7:0]       state;
        logic [TOD_W-1:0] tod;
        logic [DAYS-1:0]  mask;
        logic [31:0]      id;
    } entry_t;

    // controls from the sequencer to the query unit
    typedef struct packed {
        logic load;       // new word accepted, latch query time
        logic entry_vld;  // read data carries a scanned entry
    } qctl_t;

endpackage

/* design/wst_query_unit.sv */
// Query evaluator: per scanned entry, seven day offsets in parallel, then
// a running best (smallest time since firing). Depends on wst_pkg.
module wst_query_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  wst_pkg::qctl_t             ctl,
    input  logic [2:0]                 day_of_week,
    input  logic [wst_pkg::TOD_W-1:0]  time_of_day,
    input  wst_pkg::entry_t            entry,
    output logic [7:0]                 best_state,
    output logic                       busy
);
    import wst_pkg::*;

    logic [AGO_W:0]   nowp_reg;          // query time mod week, plus one week
    logic [AGO_W-1:0] now_raw;
    logic [AGO_W-1:0] now_mod;

    logic [AGO_W-1:0] ago_next [DAYS];
    logic [AGO_W-1:0] ago_reg  [DAYS];
    logic [DAYS-1:0]  hit_next;
    logic [DAYS-1:0]  hit_reg;
    logic [7:0]       a_state_reg;
    logic             a_vld_reg;

    logic [AGO_W-1:0] min_ago;
    logic             min_found;
    logic [AGO_W-1:0] best_ago_reg;
    logic [7:0]       best_state_reg;

    // query time folded into one week
    always_comb
    begin
        now_raw = AGO_W'(day_of_week) * AGO_W'(DAY_SECS) + AGO_W'(time_of_day);
        now_mod = (now_raw >= WEEK_SECS) ? (now_raw - WEEK_SECS) : now_raw;
    end

    // stage A: time since firing on each day
    always_comb
    begin
        logic [AGO_W-1:0] fire;
        logic [AGO_W:0]   diff;
        for (int d = 0; d < DAYS; d++)
        begin
            fire        = AGO_W'(d) * AGO_W'(DAY_SECS) + AGO_W'(entry.tod);
            diff        = nowp_reg - {1'b0, fire};
            ago_next[d] = (diff >= {1'b0, WEEK_SECS}) ? AGO_W'(diff - {1'b0, WEEK_SECS})
                                                      : AGO_W'(diff);
            hit_next[d] = entry.mask[d] && (entry.id != 32'd0);
        end
    end

    // stage B: smallest over the days, lower day wins ties
    always_comb
    begin
        min_ago   = WEEK_SECS;
        min_found = 1'b0;
        for (int d = 0; d < DAYS; d++)
        begin
            if (hit_reg[d] && (!min_found || ago_reg[d] < min_ago))
            begin
                min_ago   = ago_reg[d];
                min_found = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= ctl.entry_vld;
        end
    end

    // datapath; earlier entry keeps the win on equal age
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            nowp_reg       <= {1'b0, now_mod} + {1'b0, WEEK_SECS};
            best_ago_reg   <= WEEK_SECS;
            best_state_reg <= 8'd0;
        end
        else if (a_vld_reg && min_found && (min_ago < best_ago_reg))
        begin
            best_ago_reg   <= min_ago;
            best_state_reg <= a_state_reg;
        end
        if (ctl.entry_vld)
        begin
            ago_reg     <= ago_next;
            hit_reg     <= hit_next;
            a_state_reg <= entry.state;
        end
    end

    assign best_state = best_state_reg;
    assign busy       = a_vld_reg;

endmodule

/* design/weekly_schedule_table.sv */
// Top level of the weekly schedule table: sequencer, entry memory and
// output register. Depends on wst_pkg, wst_query_unit and the assert header.
//
//   channel   dir  handshake                      content
//   s_axis    in   s_axis_tvalid / s_axis_tready  tuser kind, tdata operands
//   m_axis    out  m_axis_tvalid / m_axis_tready  tdata ok, state, count
//
// One word at a time: the table is scanned one entry per cycle through the single
// read port of the entry memory, then the query unit pipeline drains and the
// write-back or result follows; a successful remove first fetches the last entry
// and moves it into the gap.
// Reset clears the entry count and all control; the memory is not cleared.
// A stalled result is held in the output register; the next word is taken
// meanwhile, and its own result waits for the register to empty.
`include "weekly_schedule_table_assert.svh"

module weekly_schedule_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [2:0] day_of_week, [19:3] time_of_day, [51:20] event_id,
    // [58:52] fire_days, [66:59] event_state, [71:67] zero
    input  logic [wst_pkg::IN_W-1:0]    s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]                  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [0] ok, [8:1] active_state, [13:9] event_count, [15:14] zero
    output logic [wst_pkg::OUT_W-1:0]   m_axis_tdata
);
    import wst_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FETCH,
        ST_MOVE,
        ST_RESP
    } state_t;

    // input word fields
    logic [2:0]       in_day;
    logic [TOD_W-1:0] in_tod;
    logic [31:0]      in_id;
    logic [DAYS-1:0]  in_mask;
    logic [7:0]       in_state;
    logic             accept;

    assign in_day   = s_axis_tdata[2:0];
    assign in_tod   = s_axis_tdata[19:3];
    assign in_id    = s_axis_tdata[51:20];
    assign in_mask  = s_axis_tdata[58:52];
    assign in_state = s_axis_tdata[66:59];

    // control registers
    state_t           state_reg,     state_next;
    logic [1:0]       kind_reg,      kind_next;
    logic [CNT_W-1:0] count_reg,     count_next;
    logic [CNT_W-1:0] issue_reg,     issue_next;
    logic             rd_vld_reg,    rd_vld_next;
    logic [IDX_W-1:0] data_idx_reg,  data_idx_next;
    logic             found_reg,     found_next;
    logic [IDX_W-1:0] match_idx_reg, match_idx_next;
    logic             res_ok_reg,    res_ok_next;
    logic [7:0]       res_act_reg,   res_act_next;
    logic             m_valid_reg,   m_valid_next;
    logic             m_ok_reg,      m_ok_next;
    logic [7:0]       m_act_reg,     m_act_next;
    logic [CNT_W-1:0] m_cnt_reg,     m_cnt_next;

    // operand registers
    logic [TOD_W-1:0] tod_reg;
    logic [31:0]      id_reg;
    logic [DAYS-1:0]  mask_reg;
    logic [7:0]       st_reg;

    // memory port signals
    entry_t           mem [MAX_EVENTS];
    entry_t           rdata_reg;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    entry_t           new_entry;
    logic [IDX_W-1:0] last_idx;

    // query unit
    qctl_t            q_ctl;
    logic [7:0]       q_best;
    logic             q_busy;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign new_entry     = '{state: st_reg, tod: tod_reg, mask: mask_reg, id: id_reg};
    assign last_idx      = IDX_W'(count_reg - CNT_W'(1));

    assign q_ctl.load      = accept;
    assign q_ctl.entry_vld = rd_vld_reg;

    wst_query_unit u_query (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (q_ctl),
        .day_of_week (in_day),
        .time_of_day (in_tod),
        .entry       (rdata_reg),
        .best_state  (q_best),
        .busy        (q_busy)
    );

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        rd_vld_next    = 1'b0;
        data_idx_next  = data_idx_reg;
        found_next     = found_reg;
        match_idx_next = match_idx_reg;
        res_ok_next    = res_ok_reg;
        res_act_next   = res_act_reg;
        m_valid_next   = m_valid_reg;
        m_ok_next      = m_ok_reg;
        m_act_next     = m_act_reg;
        m_cnt_next     = m_cnt_reg;
        rd_en          = 1'b0;
        rd_addr        = issue_reg[IDX_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = match_idx_reg;
        wr_data        = new_entry;

        // output word taken
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        // first entry whose id matches
        if (rd_vld_reg && !found_reg && (rdata_reg.id == id_reg))
        begin
            found_next     = 1'b1;
            match_idx_next = data_idx_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next  = s_axis_tuser;
                    issue_next = '0;
                    found_next = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issue_reg < count_reg)
                begin
                    rd_en         = 1'b1;
                    rd_vld_next   = 1'b1;
                    data_idx_next = issue_reg[IDX_W-1:0];
                    issue_next    = issue_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_vld_reg && !q_busy)
                begin
                    res_act_next = 8'd0;
                    res_ok_next  = 1'b0;
                    state_next   = ST_RESP;
                    case (kind_reg)
                        KIND_QUERY:
                        begin
                            res_ok_next  = 1'b1;
                            res_act_next = q_best;
                        end
                        KIND_UPSERT:
                        begin
                            if (tod_reg >= DAY_SECS)
                            begin
                                res_ok_next = 1'b0;
                            end
                            else if (found_reg)
                            begin
                                wr_en       = 1'b1;
                                wr_addr     = match_idx_reg;
                                res_ok_next = 1'b1;
                            end
                            else if (count_reg < CNT_W'(MAX_EVENTS))
                            begin
                                wr_en       = 1'b1;
                                wr_addr     = count_reg[IDX_W-1:0];
                                count_next  = count_reg + CNT_W'(1);
                                res_ok_next = 1'b1;
                            end
                        end
                        KIND_REMOVE:
                        begin
                            if (found_reg)
                            begin
                                state_next = ST_FETCH;
                            end
                        end
                        default:
                        begin
                            res_ok_next = 1'b0;
                        end
                    endcase
                end
            end
            // read the last entry to fill the gap
            ST_FETCH:
            begin
                rd_en      = 1'b1;
                rd_addr    = last_idx;
                state_next = ST_MOVE;
            end
            ST_MOVE:
            begin
                wr_en       = 1'b1;
                wr_addr     = match_idx_reg;
                wr_data     = rdata_reg;
                count_next  = count_reg - CNT_W'(1);
                res_ok_next = 1'b1;
                state_next  = ST_RESP;
            end
            ST_RESP:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_ok_next    = res_ok_reg;
                    m_act_next   = res_act_reg;
                    m_cnt_next   = count_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= KIND_QUERY;
            count_reg     <= '0;
            issue_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            data_idx_reg  <= '0;
            found_reg     <= 1'b0;
            match_idx_reg <= '0;
            res_ok_reg    <= 1'b0;
            res_act_reg   <= 8'd0;
            m_valid_reg   <= 1'b0;
            m_ok_reg      <= 1'b0;
            m_act_reg     <= 8'd0;
            m_cnt_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            rd_vld_reg    <= rd_vld_next;
            data_idx_reg  <= data_idx_next;
            found_reg     <= found_next;
            match_idx_reg <= match_idx_next;
            res_ok_reg    <= res_ok_next;
            res_act_reg   <= res_act_next;
            m_valid_reg   <= m_valid_next;
            m_ok_reg      <= m_ok_next;
            m_act_reg     <= m_act_next;
            m_cnt_reg     <= m_cnt_next;
        end
    end

    // operands of the accepted word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tod_reg  <= in_tod;
            id_reg   <= in_id;
            mask_reg <= in_mask;
            st_reg   <= in_state;
        end
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {2'b00, m_cnt_reg, m_act_reg, m_ok_reg};

    // checks
    `WST_ASSERT_ALWAYS(a_count_max, count_reg <= CNT_W'(MAX_EVENTS),
        "entry count above table size")
    `WST_ASSERT_IMPL(a_wr_in_range, wr_en, CNT_W'(wr_addr) <= count_reg,
        "write beyond end of table")
    `WST_ASSERT_IMPL(a_no_wr_scan, rd_vld_reg || (state_reg == ST_SCAN), !wr_en,
        "memory write while scan in flight")
    `WST_ASSERT_NEXT(a_count_on_wr, !wr_en, $stable(count_reg),
        "entry count changed without a table write")

endmodule

/* tb/tb_weekly_schedule_table.sv */
// Testbench for weekly_schedule_table: a directed table of words, then random
// phases that fill, churn and drain the event table. Depends on wst_pkg and weekly_schedule_table.
`timescale 1ns / 1ps

module tb_weekly_schedule_table;

    import wst_pkg::*;

    // kind code with no operation behind it
    localparam logic [1:0] KIND_NOP = 2'd3;

    localparam int unsigned DAY_U  = 32'(DAY_SECS);
    localparam int unsigned WEEK_U = 32'(WEEK_SECS);

    typedef struct {
        logic [1:0]       kind;
        logic [2:0]       day;
        logic [TOD_W-1:0] tod;
        logic [31:0]      id;
        logic [DAYS-1:0]  mask;
        logic [7:0]       st;
    } sched_word_t;

    typedef struct {
        logic             ok;
        logic [7:0]       state;
        logic [CNT_W-1:0] cnt;
    } sched_reply_t;

    typedef struct {
        sched_word_t  w;
        bit           typed;
        sched_reply_t r;
    } dir_row_t;

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;
    logic [1:0]        s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;

    // shadow copy of the schedule
    entry_t sched_tab [MAX_EVENTS];
    int     sched_cnt;

    sched_reply_t pending_replies [$];
    dir_row_t     dir_rows [$];
    int           mismatch_total;
    bit           calm;

    weekly_schedule_table dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Apply one word to the shadow schedule and return the reply it earns
    function automatic sched_reply_t schedule_apply(sched_word_t w);
        sched_reply_t r;
        int unsigned  now;
        int unsigned  best_ago;
        int unsigned  fire;
        int unsigned  ago;
        int           hit;
        r.ok    = 1'b0;
        r.state = 8'd0;
        hit     = -1;
        case (w.kind)
            KIND_QUERY:
            begin
                now      = int'(w.day) * DAY_U + int'(w.tod);
                best_ago = WEEK_U;
                for (int i = 0; i < sched_cnt; i++)
                begin
                    if (sched_tab[i].id != 32'd0)
                    begin
                        for (int d = 0; d < DAYS; d++)
                        begin
                            if (sched_tab[i].mask[d])
                            begin
                                fire = d * DAY_U + int'(sched_tab[i].tod);
                                ago  = (now + WEEK_U - fire) % WEEK_U;
                                if (ago < best_ago)
                                begin
                                    best_ago = ago;
                                    r.state  = sched_tab[i].state;
                                end
                            end
                        end
                    end
                end
                r.ok = 1'b1;
            end
            KIND_UPSERT:
            begin
                if (int'(w.tod) < DAY_U)
                begin
                    for (int i = 0; i < sched_cnt && hit < 0; i++)
                        if (sched_tab[i].id == w.id)
                            hit = i;
                    if (hit < 0 && sched_cnt < MAX_EVENTS)
                    begin
                        hit = sched_cnt;
                        sched_cnt++;
                    end
                    if (hit >= 0)
                    begin
                        sched_tab[hit].id    = w.id;
                        sched_tab[hit].mask  = w.mask;
                        sched_tab[hit].tod   = w.tod;
                        sched_tab[hit].state = w.st;
                        r.ok = 1'b1;
                    end
                end
            end
            KIND_REMOVE:
            begin
                for (int i = 0; i < sched_cnt && hit < 0; i++)
                    if (sched_tab[i].id == w.id)
                        hit = i;
                if (hit >= 0)
                begin
                    // last entry fills the gap
                    sched_tab[hit]           = sched_tab[sched_cnt - 1];
                    sched_tab[sched_cnt - 1] = '0;
                    sched_cnt--;
                    r.ok = 1'b1;
                end
            end
            default: ;
        endcase
        r.cnt = sched_cnt[CNT_W-1:0];
        return r;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic flag_mismatch(input string what, input sched_reply_t got,
                                 input sched_reply_t want);
        mismatch_total++;
        $display("%0t mismatch %s: ok %0d/%0d state %0d/%0d count %0d/%0d (got/exp)",
                 $realtime, what, got.ok, want.ok, got.state, want.state,
                 got.cnt, want.cnt);
    endtask

    task automatic add_row(input logic [1:0] kind, input logic [2:0] day,
                           input int unsigned tod, input logic [31:0] id,
                           input logic [6:0] mask, input logic [7:0] st,
                           input bit typed, input logic ok, input logic [7:0] as,
                           input int cnt);
        dir_row_t row;
        row.w.kind   = kind;
        row.w.day    = day;
        row.w.tod    = tod[TOD_W-1:0];
        row.w.id     = id;
        row.w.mask   = mask;
        row.w.st     = st;
        row.typed    = typed;
        row.r.ok     = ok;
        row.r.state  = as;
        row.r.cnt    = cnt[CNT_W-1:0];
        dir_rows.push_back(row);
    endtask

    // Offer one word, wait for acceptance, record the expected reply
    task automatic push_word(input sched_word_t w, input bit typed,
                             input sched_reply_t typed_r);
        sched_reply_t r;
        int           gap;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= w.kind;
        s_axis_tdata  <= {5'd0, w.st, w.mask, w.id, w.tod, w.day};
        do
            @(posedge clk);
        while (!s_axis_tready);
        r = schedule_apply(w);
        if (typed)
            r = typed_r;
        pending_replies.push_back(r);
        gap = calm ? 0 : idle_len();
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Id for a random word: small pool so the table fills, stored ids for hits
    function automatic logic [31:0] pick_id(bit prefer_stored);
        int r;
        r = $urandom_range(0, 99);
        if (prefer_stored && sched_cnt > 0 && r < 75)
            return sched_tab[$urandom_range(0, sched_cnt - 1)].id;
        if (r < 8)
            return 32'd0;
        if (r < 20)
            return $urandom;
        return $urandom_range(1, 22);
    endfunction

    function automatic sched_word_t random_word(int up_w, int rm_w);
        sched_word_t w;
        int          r;
        r      = $urandom_range(0, 99);
        w.day  = 3'($urandom_range(0, 6));
        w.tod  = TOD_W'($urandom_range(0, DAY_U - 1));
        w.mask = DAYS'($urandom);
        w.st   = 8'($urandom);
        w.id   = $urandom;
        if (r < 4)
        begin
            w.kind = KIND_NOP;
            w.day  = 3'($urandom);
            w.tod  = TOD_W'($urandom);
        end
        else if (r < 4 + up_w)
        begin
            w.kind = KIND_UPSERT;
            w.id   = pick_id($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
                w.tod = TOD_W'($urandom_range(DAY_U, (1 << TOD_W) - 1));
        end
        else if (r < 4 + up_w + rm_w)
        begin
            w.kind = KIND_REMOVE;
            w.id   = pick_id(1'b1);
        end
        else
        begin
            w.kind = KIND_QUERY;
            if ($urandom_range(0, 19) == 0)
                w.day = 3'd7;
            if ($urandom_range(0, 12) == 0)
                w.tod = TOD_W'($urandom_range(DAY_U, (1 << TOD_W) - 1));
        end
        return w;
    endfunction

    // Receiver: random back-pressure
    initial
    begin : sink
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0 && !calm)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall_left = 0;
                if ($urandom_range(0, 3) == 0)
                    stall_left = idle_len();
            end
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        sched_reply_t got;
        sched_reply_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.ok    = m_axis_tdata[0];
            got.state = m_axis_tdata[8:1];
            got.cnt   = m_axis_tdata[13:9];
            if (pending_replies.size() == 0)
            begin
                want = '{1'b0, 8'd0, 5'd0};
                flag_mismatch("unexpected word", got, want);
            end
            else
            begin
                want = pending_replies.pop_front();
                if (got.ok !== want.ok || got.state !== want.state || got.cnt !== want.cnt)
                    flag_mismatch("reply", got, want);
            end
        end
    end

    // Stimulus
    initial
    begin : stim
        sched_word_t w;
        sched_reply_t none;
        int up_w [9];
        int rm_w [9];
        up_w = '{70, 55, 40, 75, 30, 15, 60, 45, 35};
        rm_w = '{10, 20, 25, 10, 35, 55, 15, 25, 30};
        none           = '{1'b0, 8'd0, 5'd0};
        mismatch_total = 0;
        calm           = 1'b0;
        sched_cnt      = 0;
        for (int i = 0; i < MAX_EVENTS; i++)
            sched_tab[i] = '0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_QUERY;

        // empty table, refusals, no-op kind
        add_row(KIND_QUERY,  3'd0, 0,      32'd0,        7'h00, 8'h00, 1'b1, 1'b1, 8'h00, 0);
        add_row(KIND_REMOVE, 3'd0, 0,      32'd5,        7'h00, 8'h00, 1'b1, 1'b0, 8'h00, 0);
        add_row(KIND_NOP,    3'd0, 0,      32'd0,        7'h00, 8'h00, 1'b1, 1'b0, 8'h00, 0);
        add_row(KIND_UPSERT, 3'd0, 86400,  32'd9,        7'h7F, 8'h12, 1'b1, 1'b0, 8'h00, 0);
        add_row(KIND_UPSERT, 3'd7, 131071, 32'hFFFFFFFF, 7'h7F, 8'hFF, 1'b1, 1'b0, 8'h00, 0);
        // extremes stored, id zero stored but skipped by queries
        add_row(KIND_UPSERT, 3'd0, 86399,  32'hFFFFFFFF, 7'h7F, 8'hFF, 1'b1, 1'b1, 8'h00, 1);
        add_row(KIND_QUERY,  3'd0, 0,      32'd0,        7'h00, 8'h00, 1'b0, 1'b0, 8'h00, 0);
        add_row(KIND_UPSERT, 3'd0, 0,      32'd0,        7'h7F, 8'hAA, 1'b1, 1'b1, 8'h00, 2);
        add_row(KIND_QUERY,  3'd7, 131071, 32'd0,        7'h00, 8'h00, 1'b0, 1'b0, 8'h00, 0);
        // replace in place
        add_row(KIND_UPSERT, 3'd0, 0,      32'hFFFFFFFF, 7'h01, 8'h55, 1'b1, 1'b1, 8'h00, 2);
        add_row(KIND_QUERY,  3'd0, 0,      32'd0,        7'h00, 8'h00, 1'b0, 1'b0, 8'h00, 0);
        // empty mask, then a tie on the same firing second
        add_row(KIND_UPSERT, 3'd0, 100,    32'd1,        7'h00, 8'h11, 1'b1, 1'b1, 8'h00, 3);
        add_row(KIND_UPSERT, 3'd0, 43200,  32'd2,        7'h40, 8'h22, 1'b1, 1'b1, 8'h00, 4);
        add_row(KIND_UPSERT, 3'd0, 43200,  32'd3,        7'h40, 8'h33, 1'b1, 1'b1, 8'h00, 5);
        add_row(KIND_QUERY,  3'd6, 43200,  32'd0,        7'h00, 8'h00, 1'b0, 1'b0, 8'h00, 0);
        add_row(KIND_QUERY,  3'd6, 131071, 32'd0,        7'h00, 8'h00, 1'b0, 1'b0, 8'h00, 0);
        add_row(KIND_QUERY,  3'd0, 86399,  32'd0,        7'h00, 8'h00, 1'b0, 1'b0, 8'h00, 0);
        // removes: first entry, id zero, absent id, the entry moved into the first slot
        add_row(KIND_REMOVE, 3'd0, 0,      32'hFFFFFFFF, 7'h00, 8'h00, 1'b1, 1'b1, 8'h00, 4);
        add_row(KIND_QUERY,  3'd6, 50000,  32'd0,        7'h00, 8'h00, 1'b0, 1'b0, 8'h00, 0);
        add_row(KIND_REMOVE, 3'd0, 0,      32'd0,        7'h00, 8'h00, 1'b1, 1'b1, 8'h00, 3);
        add_row(KIND_REMOVE, 3'd0, 0,      32'd7,        7'h00, 8'h00, 1'b1, 1'b0, 8'h00, 3);
        add_row(KIND_REMOVE, 3'd0, 0,      32'd3,        7'h00, 8'h00, 1'b1, 1'b1, 8'h00, 2);
        add_row(KIND_NOP,    3'd7, 131071, 32'hFFFFFFFF, 7'h7F, 8'hFF, 1'b1, 1'b0, 8'h00, 2);
        // existing id with a bad time is still refused
        add_row(KIND_UPSERT, 3'd0, 86400,  32'd2,        7'h7F, 8'h77, 1'b1, 1'b0, 8'h00, 2);
        add_row(KIND_QUERY,  3'd3, 0,      32'd0,        7'h00, 8'h00, 1'b0, 1'b0, 8'h00, 0);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            push_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].r);

        // random phases; some run without any idling
        for (int p = 0; p < 9; p++)
        begin
            calm = (p == 3 || p == 7);
            for (int n = 0; n < 50; n++)
            begin
                w = random_word(up_w[p], rm_w[p]);
                push_word(w, 1'b0, none);
            end
        end
        calm = 1'b0;

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (mismatch_total == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
